>>> sv/mbs_pkg.sv
package mbs_pkg;

	localparam int SAMPLE_W       = 14;
	localparam int MAG_W          = 17;
	localparam int COUNT_W        = 14;
	localparam int HIST_BINS_DEF  = 4096;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// item mode codes
	localparam logic MODE_FILL = 1'b0;  // count sample into the histogram
	localparam logic MODE_EMIT = 1'b1;  // return sample minus baseline

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} mbs_state_t;

	// sequencer -> histogram unit
	typedef struct packed {
		logic lookup;      // read bin at the item address
		logic update;      // write back incremented count, track mode
		logic clear_step;  // zero one bin of the sweep
		logic clear_best;  // reset the mode tracker
	} mbs_hist_ctrl_t;

endpackage

>>> sv/mbs_hist.sv
module mbs_hist #(
	parameter int HIST_BINS = mbs_pkg::HIST_BINS_DEF,
	parameter int BIN_W     = $clog2(HIST_BINS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbs_pkg::mbs_hist_ctrl_t ctrl,
	input  logic [BIN_W-1:0]      addr,
	input  logic [BIN_W-1:0]      clr_addr,
	output logic [BIN_W-1:0]      best_bin
);
	import mbs_pkg::*;

	logic [COUNT_W-1:0] mem [HIST_BINS];
	logic [COUNT_W-1:0] rd_q;
	logic [BIN_W-1:0]   bin_q;
	logic [BIN_W-1:0]   best_bin_q;
	logic [COUNT_W-1:0] best_count_q;

	logic [COUNT_W-1:0] cnt_inc;
	logic               take_best;
	logic               we;
	logic [BIN_W-1:0]   waddr;
	logic [COUNT_W-1:0] wdata;

	// saturating increment and tie-break toward the lower bin
	assign cnt_inc   = (rd_q == COUNT_MAX) ? rd_q : rd_q + COUNT_W'(1);
	assign take_best = (cnt_inc > best_count_q) ||
	                   ((cnt_inc == best_count_q) && (bin_q < best_bin_q));

	assign we    = ctrl.update || ctrl.clear_step;
	assign waddr = ctrl.clear_step ? clr_addr : bin_q;
	assign wdata = ctrl.clear_step ? '0 : cnt_inc;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctrl.lookup) begin
			rd_q  <= mem[addr];
			bin_q <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_bin_q   <= '0;
			best_count_q <= '0;
		end else if (ctrl.clear_best) begin
			best_bin_q   <= '0;
			best_count_q <= '0;
		end else if (ctrl.update && take_best) begin
			best_bin_q   <= bin_q;
			best_count_q <= cnt_inc;
		end
	end

	assign best_bin = best_bin_q;

	// one memory port: never write and read in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.lookup, ctrl.update, ctrl.clear_step}))
		else $error("histogram port conflict");

	// the tracked peak only grows within a channel
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.update |=> best_count_q >= $past(best_count_q))
		else $error("mode count decreased");

	// tracker reset never lands on a write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear_best |-> !ctrl.update)
		else $error("tracker reset during write-back");

endmodule

>>> sv/mode_baseline_subtract_core.sv
// Histogram-mode pedestal removal for one channel at a time. Each channel is
// sent twice: mode 0 beats fill a HIST_BINS-bin histogram (samples outside
// 0..HIST_BINS-1 are skipped, counts saturate) while the most populated bin is
// tracked, lowest index on ties; mode 1 beats return 2*sample - (2*bin + 1),
// the residual against the bin centre in half counts, or 2*sample when
// baseline_enable is 0. A mode 1 beat with last set ends the channel: the
// tracker resets at once and the histogram RAM is zeroed by a sweep over
// all HIST_BINS bins (4096 by default), also run right after reset; no beat
// is taken during the sweep. An in-range mode 0 beat reads its bin, then
// writes it back on the single-port histogram RAM, and no beat is taken
// during the write-back; other beats skip it. Otherwise a mode 1 beat is held
// off only while the result register is full and stalled. cfg_ready is always
// high; write the register only between channels.
module mode_baseline_subtract_core #(
	parameter int HIST_BINS = mbs_pkg::HIST_BINS_DEF,
	parameter int BIN_W     = $clog2(HIST_BINS),
	parameter int RES_W     = (BIN_W + 3 > 16) ? BIN_W + 3 : 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         mode,
	input  logic signed [mbs_pkg::SAMPLE_W-1:0] sample,
	input  logic                         last,
	// result channel
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [RES_W-1:0]      residual_half,
	output logic [BIN_W-1:0]             baseline_bin,
	output logic                         end_of_channel
);
	import mbs_pkg::*;

	mbs_state_t     st_q, st_nxt;
	mbs_hist_ctrl_t hctrl;

	logic             baseline_enable_q;
	logic [BIN_W-1:0] clr_q;
	logic             clr_done;

	logic             accept;
	logic             emit;
	logic             in_range;
	logic [MAG_W-1:0] mag;
	logic [BIN_W-1:0] bin_addr;
	logic [BIN_W-1:0] best_bin;

	logic [BIN_W-1:0]        bb_sel;
	logic signed [RES_W-1:0] twice_s;
	logic signed [RES_W-1:0] center;
	logic signed [RES_W-1:0] residual;

	logic                    result_valid_q;
	logic signed [RES_W-1:0] residual_q;
	logic [BIN_W-1:0]        baseline_bin_q;
	logic                    end_of_channel_q;

	// register write port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			baseline_enable_q <= cfg_data;
		end
	end

	// bin address and range check
	assign mag      = MAG_W'(sample[SAMPLE_W-2:0]);
	assign in_range = !sample[SAMPLE_W-1] && (mag < MAG_W'(HIST_BINS));
	assign bin_addr = mag[BIN_W-1:0];

	// sequencer: next state
	assign clr_done = (clr_q == BIN_W'(HIST_BINS - 1));

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_done) st_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && (mode == MODE_FILL) && in_range) st_nxt = ST_UPDATE;
				else if (accept && (mode == MODE_EMIT) && last) st_nxt = ST_CLEAR;
			end
			ST_UPDATE: begin
				st_nxt = ST_IDLE;
			end
			default: st_nxt = ST_CLEAR;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		item_stall = 1'b1;
		hctrl      = '0;
		unique case (st_q)
			ST_CLEAR: begin
				hctrl.clear_step = 1'b1;
			end
			ST_IDLE: begin
				// only an emitting beat needs room in the result register
				item_stall = (mode == MODE_EMIT) && result_valid_q && result_stall;
			end
			ST_UPDATE: begin
				hctrl.update = 1'b1;
			end
			default: ;
		endcase
		accept           = item_valid && !item_stall;
		emit             = accept && (mode == MODE_EMIT);
		hctrl.lookup     = accept && (mode == MODE_FILL) && in_range;
		hctrl.clear_best = emit && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_done ? '0 : clr_q + BIN_W'(1);
			end
		end
	end

	mbs_hist #(
		.HIST_BINS (HIST_BINS),
		.BIN_W     (BIN_W)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (hctrl),
		.addr     (bin_addr),
		.clr_addr (clr_q),
		.best_bin (best_bin)
	);

	// residual in half counts against the bin centre
	assign bb_sel   = baseline_enable_q ? best_bin : '0;
	assign twice_s  = RES_W'($signed({sample, 1'b0}));
	assign center   = $signed(RES_W'({bb_sel, 1'b1}));
	assign residual = baseline_enable_q ? twice_s - center : twice_s;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			residual_q       <= residual;
			baseline_bin_q   <= bb_sel;
			end_of_channel_q <= last;
		end
	end

	assign result_valid   = result_valid_q;
	assign residual_half  = residual_q;
	assign baseline_bin   = baseline_bin_q;
	assign end_of_channel = end_of_channel_q;

	// end of channel always starts a histogram sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> st_q == ST_CLEAR)
		else $error("no clear after end of channel");

	// a write-back follows only a histogram lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_UPDATE |-> $past(hctrl.lookup))
		else $error("update without lookup");

	// never overwrite a result that is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(result_valid_q && result_stall))
		else $error("result register overrun");

endmodule

>>> test/mode_baseline_subtract_checker.sv
`timescale 1ns / 100ps

module mode_baseline_subtract_checker #(
	parameter int BINS  = mbs_pkg::HIST_BINS_DEF,
	parameter int BIN_W = $clog2(BINS),
	parameter int RES_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  logic                       mode,
	input  logic signed [mbs_pkg::SAMPLE_W-1:0] sample,
	input  logic                       last,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic signed [RES_W-1:0]    residual_half,
	input  logic [BIN_W-1:0]           baseline_bin,
	input  logic                       end_of_channel,
	output int                         fail_count,
	output int                         pending
);
	import mbs_pkg::*;

	typedef struct packed {
		logic signed [RES_W-1:0] residual;
		logic [BIN_W-1:0]        bin;
		logic                    eoc;
	} residual_beat_t;

	residual_beat_t     residual_q[$];
	logic [COUNT_W-1:0] bin_tally [BINS];
	logic [BIN_W-1:0]   peak_bin;
	logic [COUNT_W-1:0] peak_count;
	logic               subtract_on;
	int                 errors = 0;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic forget_channel();
		for (int i = 0; i < BINS; i++)
			bin_tally[i] = '0;
		peak_bin   = '0;
		peak_count = '0;
	endtask

	// one accepted item: fill the histogram or queue the residual it owes
	task automatic predict_beat(input logic m, input logic signed [SAMPLE_W-1:0] s,
			input logic l);
		int                 sv;
		int                 r;
		logic [BIN_W-1:0]   b;
		logic [COUNT_W-1:0] c;
		residual_beat_t     e;
		sv = s;
		if (m == MODE_FILL) begin
			if (sv >= 0 && sv < BINS) begin
				b = sv[BIN_W-1:0];
				c = bin_tally[b];
				if (c != COUNT_MAX)
					c = c + 1'b1;
				bin_tally[b] = c;
				if (c > peak_count || (c == peak_count && b < peak_bin)) begin
					peak_count = c;
					peak_bin   = b;
				end
			end
		end else begin
			if (subtract_on) begin
				e.bin = peak_bin;
				r = 2 * sv - (2 * int'(peak_bin) + 1);
			end else begin
				e.bin = '0;
				r = 2 * sv;
			end
			e.residual = r[RES_W-1:0];
			e.eoc      = l;
			residual_q.push_back(e);
			if (l)
				forget_channel();
		end
	endtask

	task automatic check_beat();
		residual_beat_t e;
		if (residual_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result residual %0d bin %0d",
				residual_half, baseline_bin));
			return;
		end
		e = residual_q.pop_front();
		if (residual_half !== e.residual)
			report_mismatch($sformatf("residual_half %0d, want %0d",
				residual_half, e.residual));
		if (baseline_bin !== e.bin)
			report_mismatch($sformatf("baseline_bin %0d, want %0d", baseline_bin, e.bin));
		if (end_of_channel !== e.eoc)
			report_mismatch($sformatf("end_of_channel %b, want %b", end_of_channel, e.eoc));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forget_channel();
			subtract_on = 1'b1;
			residual_q.delete();
			pending    <= 0;
			fail_count <= errors;
		end else begin
			if (cfg_valid && cfg_ready)
				subtract_on = cfg_data;
			if (item_valid && !item_stall)
				predict_beat(mode, sample, last);
			if (result_valid && !result_stall)
				check_beat();
			pending    <= residual_q.size();
			fail_count <= errors;
		end
	end

endmodule

>>> test/tb_mode_baseline_subtract_core.sv
`timescale 1ns / 100ps

module tb_mode_baseline_subtract_core;
	import mbs_pkg::*;

	localparam int BIN_W = $clog2(HIST_BINS_DEF);
	localparam int RES_W = 16;

	localparam logic BASELINE_OFF = 1'b0;
	localparam logic BASELINE_ON  = 1'b1;

	localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
	localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
	localparam int TOP_BIN    = HIST_BINS_DEF - 1;

	localparam int RANDOM_BEATS  = 800;
	// gap-free fill run on one bin so it leads by a wide margin
	localparam int PEAK_HITS     = 40;
	// wait at the end of a drain; this covers the fill write-back
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 32;
	// watchdog bound on the whole run, sweeps included
	localparam int CYCLE_LIMIT   = 2_000_000;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic                       cfg_data     = 1'b1;
	logic                       item_valid   = 1'b0;
	logic                       item_stall;
	logic                       mode         = 1'b0;
	logic signed [SAMPLE_W-1:0] sample       = '0;
	logic                       last         = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [RES_W-1:0]    residual_half;
	logic [BIN_W-1:0]           baseline_bin;
	logic                       end_of_channel;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int beats_sent  = 0;
	int quiet_left  = 0;   // beats left in a gap-free stretch
	int stall_left  = 0;   // cycles left at the current result_stall level
	bit no_gaps     = 1'b0;

	mode_baseline_subtract_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.sample         (sample),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.residual_half  (residual_half),
		.baseline_bin   (baseline_bin),
		.end_of_channel (end_of_channel)
	);

	mode_baseline_subtract_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.sample         (sample),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.residual_half  (residual_half),
		.baseline_bin   (baseline_bin),
		.end_of_channel (end_of_channel),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("mode_baseline_subtract_core test failed");
			$finish;
		end
	end

	// Result back-pressure. Levels are held for random runs: mostly short
	// ready spells and short stalls, now and then a long stall, and now and
	// then a long stretch with no stall at all.
	always @(posedge clk) begin
		int r;
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				result_stall <= 1'b0;
				stall_left = $urandom_range(0, 7);
			end else if (r < 85) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else if (r < 95) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(3, 11);
			end else if (r < 98) begin
				result_stall <= 1'b0;
				stall_left = $urandom_range(50, 200);
			end else begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(30, 79);
			end
		end
	end

	// Idle cycles before the next beat: mostly none or a few, rarely long,
	// with occasional gap-free runs so back-to-back beats hit every phase.
	function automatic int next_gap();
		int r;
		if (no_gaps)
			return 0;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Presents one beat and returns at the edge that takes it. Valid stays
	// high after the take; the next call either swaps the payload in the same
	// step (back-to-back) or drops valid for its gap. Anything else that
	// waits must drop valid first, see drain().
	task automatic push_beat(input logic m, input int s, input logic l);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode       <= m;
		sample     <= s[SAMPLE_W-1:0];
		last       <= l;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		beats_sent++;
	endtask

	// Sender holds off until every queued residual has come back, then lets
	// the block finish any fill write-back still in flight.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// bin edges and range limits of the sample field
	function automatic int edge_sample();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return TOP_BIN;
			2: return HIST_BINS_DEF;
			3: return -1;
			4: return SAMPLE_MIN;
			default: return SAMPLE_MAX;
		endcase
	endfunction

	// full 14-bit range, every bit free
	function automatic int any_sample();
		return int'($urandom_range(0, 2 ** SAMPLE_W - 1)) + SAMPLE_MIN;
	endfunction

	// Fill data clusters around a peak so ties and close races between
	// neighboring bins are common; the rest is spread, junk, or edges.
	function automatic int fill_sample(input int peak);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return peak + $urandom_range(0, 2);
		if (r < 75)
			return $urandom_range(0, TOP_BIN);
		if (r < 90)
			return any_sample();
		return edge_sample();
	endfunction

	function automatic int emit_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return any_sample();
		if (r < 80)
			return $urandom_range(0, TOP_BIN);
		return edge_sample();
	endfunction

	// One channel: a fill pass, then an emit pass closed by last. About one
	// channel in ten is malformed: stray emits in the fill pass, last in the
	// middle of either pass; about one in four has an emit pass of random length.
	task automatic random_channel();
		int fill_len;
		int emit_len;
		int peak;
		bit broken;
		fill_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
		case ($urandom_range(0, 9))
			0: peak = 0;
			1: peak = TOP_BIN;
			default: peak = $urandom_range(0, TOP_BIN);
		endcase
		broken = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < fill_len; k++) begin
			push_beat(MODE_FILL, fill_sample(peak),
				(k == fill_len - 1 && $urandom_range(0, 3) != 0)
				|| (broken && $urandom_range(0, 7) == 0));
			if (broken && $urandom_range(0, 5) == 0)
				push_beat(MODE_EMIT, emit_sample(), 1'b0);
		end
		emit_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, fill_len + 4) : fill_len;
		for (int k = 0; k < emit_len; k++)
			push_beat(MODE_EMIT, emit_sample(),
				k == emit_len - 1 || (broken && $urandom_range(0, 9) == 0));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// the block sweeps its RAM after reset; the first beat simply waits
		write_enable(BASELINE_ON);

		// emit on an empty histogram: baseline is bin 0
		push_beat(MODE_EMIT, 0, 1'b0);

		// out-of-range samples are not counted
		push_beat(MODE_FILL, SAMPLE_MIN, 1'b0);
		push_beat(MODE_FILL, SAMPLE_MAX, 1'b0);
		push_beat(MODE_FILL, HIST_BINS_DEF, 1'b0);
		push_beat(MODE_FILL, -1, 1'b0);
		// lowest and highest bins, then a tie that the lower bin wins
		push_beat(MODE_FILL, 0, 1'b0);
		push_beat(MODE_FILL, TOP_BIN, 1'b0);
		push_beat(MODE_FILL, TOP_BIN, 1'b0);
		push_beat(MODE_FILL, 10, 1'b0);
		push_beat(MODE_FILL, 10, 1'b0);
		// last on a fill beat: no result, no clear
		push_beat(MODE_FILL, 10, 1'b1);

		push_beat(MODE_EMIT, SAMPLE_MAX, 1'b0);
		push_beat(MODE_EMIT, SAMPLE_MIN, 1'b0);
		push_beat(MODE_EMIT, 10, 1'b1);

		// histogram must be clear again
		push_beat(MODE_EMIT, 5, 1'b1);

		// pass-through: fill still counts, emit doubles, last still clears
		drain();
		write_enable(BASELINE_OFF);
		push_beat(MODE_FILL, 300, 1'b0);
		push_beat(MODE_FILL, 300, 1'b0);
		push_beat(MODE_EMIT, SAMPLE_MAX, 1'b0);
		push_beat(MODE_EMIT, SAMPLE_MIN, 1'b0);
		push_beat(MODE_EMIT, 0, 1'b1);

		drain();
		write_enable(BASELINE_ON);
		push_beat(MODE_EMIT, 100, 1'b1);

		// Back-to-back fills on the top bin, then a few hits elsewhere.
		// Emitting the most negative sample against the top bin gives the
		// lowest residual the block can make.
		no_gaps = 1'b1;
		for (int k = 0; k < PEAK_HITS; k++)
			push_beat(MODE_FILL, TOP_BIN, 1'b0);
		repeat (3) push_beat(MODE_FILL, 7, 1'b0);
		no_gaps = 1'b0;
		push_beat(MODE_EMIT, SAMPLE_MIN, 1'b0);
		push_beat(MODE_EMIT, SAMPLE_MAX, 1'b1);

		// --- random channels ---
		while (beats_sent < RANDOM_BEATS) begin
			random_channel();
			// between channels: sometimes retune, sometimes just wait dry
			case ($urandom_range(0, 9))
				0, 1: begin
					drain();
					write_enable(($urandom_range(0, 3) != 0) ? BASELINE_ON : BASELINE_OFF);
				end
				2: drain();
				default: ;
			endcase
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("mode_baseline_subtract_core test passed");
		else
			$display("mode_baseline_subtract_core test failed");
		$finish;
	end

endmodule
